@@ rtl/core/bfa_pkg.sv @@
// package for the bitmap frame allocator
// map geometry, opcodes and sequencer states; no dependencies
package bfa_pkg;
  localparam int unsigned Frames = 8192;
  localparam int unsigned PageShift = 12;
  localparam int unsigned MapWords = (Frames + 31) / 32;
  localparam int unsigned WordAw = $clog2(MapWords);
  localparam int unsigned FrameW = $clog2(Frames + 1);
  localparam int unsigned CntW = 14;

  typedef enum logic [2:0] {
    OpAllocOne = 3'd0,
    OpAllocRun = 3'd1,
    OpFree     = 3'd2,
    OpReserve  = 3'd3,
    OpRelease  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StScanRd,
    StScan,
    StMarkRd,
    StMark,
    StCntRd,
    StCount,
    StDone
  } state_e;
endpackage

@@ rtl/core/bitmap_frame_allocator.sv @@
// top level of the bitmap frame allocator
// uses bfa_pkg; holds the used-bit map memory and the scan sequencer
//
//  channel | signals                                   | dir
//  cmd     | start_i, busy_o, opcode/address/...        | in
//  result  | done_o, success_o, frame_address_o, counts | out
//  config  | cfg_we_i, cfg_frame_limit_i                | in
//
// one frame bit per cycle through a shared bit unit, except where a read of the next map word
// comes first; an item takes a search pass (alloc only), a marking pass and a count pass,
// then posts the result
// reset: a clearing pass writes all ones to each of the MapWords (256) words, busy meanwhile
// results show for one cycle on done_o; the receiver cannot stall
module bitmap_frame_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [2:0]               opcode_i,
  input  logic [31:0]              address_i,
  input  logic [32:0]              end_address_i,
  input  logic [13:0]              run_length_i,
  input  logic                     cfg_we_i,
  input  logic [13:0]              cfg_frame_limit_i,
  output logic                     done_o,
  output logic                     success_o,
  output logic [31:0]              frame_address_o,
  output logic [13:0]              used_count_o,
  output logic [13:0]              free_count_o
);
  import bfa_pkg::*;

  logic [31:0] mem [MapWords];
  logic [31:0] rdata_q;
  logic [31:0] word_q;
  logic        fresh_q;

  state_e state_q, state_d;
  logic [13:0] total_q;
  logic [WordAw:0] clr_q;
  logic [FrameW-1:0] f_q, hi_q, start_q, tot_q, fa_q;
  logic [CntW-1:0] run_q, want_q, used_q;
  logic ok_q, setv_q;

  logic clearing, accept;
  logic [FrameW-1:0] tot_w, f_nx, hit_start;
  logic [33:0] res_end, rel_start, lim, rel_e;
  logic [33:0] a_f0, r_f1, l_f0, l_f1;
  logic [FrameW-1:0] dec_lo, dec_hi;
  logic [CntW-1:0] dec_want;
  logic dec_setv, dec_ok, dec_scan, dec_any;
  logic [WordAw-1:0] waddr;
  logic last_in_word, bit_cur, hit, scan_end, cnt_end;
  logic [31:0] mark_base, mark_word;
  logic mem_we;
  logic [WordAw-1:0] mem_wa;
  logic [31:0] mem_wd;

  assign clearing = (clr_q != (WordAw + 1)'(MapWords));
  assign accept = start_i && !busy_o;

  // effective total and address decoding
  assign tot_w = (32'(total_q) < Frames) ? FrameW'(total_q) : FrameW'(Frames);

  assign res_end   = {1'b0, end_address_i} + 34'((1 << PageShift) - 1);
  assign rel_start = {2'b0, address_i} + 34'((1 << PageShift) - 1);
  assign lim       = 34'(tot_w) << PageShift;
  assign rel_e     = ({1'b0, end_address_i} > lim) ? lim : {1'b0, end_address_i};

  assign a_f0 = {2'b0, address_i} >> PageShift;
  assign r_f1 = res_end >> PageShift;
  assign l_f0 = rel_start >> PageShift;
  assign l_f1 = rel_e >> PageShift;

  // bit unit: current frame bit, run match and word update
  assign waddr        = f_q[WordAw+4:5];
  assign last_in_word = (f_q[4:0] == 5'd31);
  assign f_nx         = f_q + FrameW'(1);
  assign bit_cur      = rdata_q[f_q[4:0]];
  assign hit          = !bit_cur && ((run_q + CntW'(1)) == want_q);
  assign hit_start    = (run_q == '0) ? f_q : start_q;
  assign scan_end     = (f_nx >= hi_q);
  assign cnt_end      = (f_nx >= tot_q);
  assign mark_base    = fresh_q ? rdata_q : word_q;

  always_comb begin
    mark_word = mark_base;
    mark_word[f_q[4:0]] = setv_q;
  end

  always_comb begin
    dec_lo   = '0;
    dec_hi   = '0;
    dec_want = CntW'(1);
    dec_setv = 1'b0;
    dec_ok   = 1'b1;
    dec_scan = 1'b0;
    case (opcode_i)
      OpAllocOne: begin
        dec_hi   = tot_w;
        dec_setv = 1'b1;
        dec_ok   = 1'b0;
        dec_scan = 1'b1;
      end
      OpAllocRun: begin
        dec_lo   = FrameW'(1);
        dec_hi   = (run_length_i == '0) ? '0 : tot_w;
        dec_want = run_length_i;
        dec_setv = 1'b1;
        dec_ok   = 1'b0;
        dec_scan = 1'b1;
      end
      OpFree: begin
        if (a_f0 < 34'(tot_w)) begin
          dec_lo = FrameW'(a_f0);
          dec_hi = FrameW'(a_f0 + 34'd1);
        end
      end
      OpReserve: begin
        dec_lo   = (a_f0 > 34'(tot_w)) ? tot_w : FrameW'(a_f0);
        dec_hi   = (r_f1 > 34'(tot_w)) ? tot_w : FrameW'(r_f1);
        dec_setv = 1'b1;
      end
      OpRelease: begin
        dec_lo = (l_f0 > 34'(tot_w)) ? tot_w : FrameW'(l_f0);
        dec_hi = FrameW'(l_f1);
      end
      default: dec_ok = 1'b0;
    endcase
    dec_any = (dec_lo < dec_hi);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (!dec_any) state_d = (tot_w == '0) ? StDone : StCntRd;
          else if (dec_scan) state_d = StScanRd;
          else state_d = StMarkRd;
        end
      end
      StScanRd: state_d = StScan;
      StScan: begin
        if (hit) state_d = StMarkRd;
        else if (scan_end) state_d = StCntRd;
        else if (last_in_word) state_d = StScanRd;
      end
      StMarkRd: state_d = StMark;
      StMark: begin
        if (scan_end) state_d = StCntRd;
        else if (last_in_word) state_d = StMarkRd;
      end
      StCntRd: state_d = StCount;
      StCount: begin
        if (cnt_end) state_d = StDone;
        else if (last_in_word) state_d = StCntRd;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    busy_o = (state_q != StIdle) || clearing;
    mem_we = 1'b0;
    mem_wa = waddr;
    mem_wd = mark_word;
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_q[WordAw-1:0];
      mem_wd = '1;
    end else if (state_q == StMark && (scan_end || last_in_word)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[waddr];
  end

  // sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      total_q         <= 14'd8192;
      clr_q           <= '0;
      f_q             <= '0;
      hi_q            <= '0;
      start_q         <= '0;
      tot_q           <= '0;
      fa_q            <= '0;
      run_q           <= '0;
      want_q          <= '0;
      used_q          <= '0;
      ok_q            <= 1'b0;
      setv_q          <= 1'b0;
      word_q          <= '0;
      fresh_q         <= 1'b0;
      done_o          <= 1'b0;
      success_o       <= 1'b0;
      frame_address_o <= '0;
      used_count_o    <= '0;
      free_count_o    <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (cfg_we_i) total_q <= cfg_frame_limit_i;
      if (clearing) clr_q <= clr_q + (WordAw + 1)'(1);
      case (state_q)
        StIdle: begin
          if (accept) begin
            f_q    <= dec_any ? dec_lo : '0;
            hi_q   <= dec_hi;
            tot_q  <= tot_w;
            want_q <= dec_want;
            setv_q <= dec_setv;
            ok_q   <= dec_ok;
            run_q  <= '0;
            used_q <= '0;
            fa_q   <= '0;
          end
        end
        StScan: begin
          if (!bit_cur) begin
            run_q <= run_q + CntW'(1);
            if (run_q == '0) start_q <= f_q;
          end else begin
            run_q <= '0;
          end
          if (hit) begin
            ok_q <= 1'b1;
            fa_q <= hit_start;
            f_q  <= hit_start;
            hi_q <= f_nx;
          end else if (scan_end) begin
            f_q <= '0;
          end else begin
            f_q <= f_nx;
          end
        end
        StMarkRd: fresh_q <= 1'b1;
        StMark: begin
          word_q  <= mark_word;
          fresh_q <= 1'b0;
          f_q     <= scan_end ? '0 : f_nx;
        end
        StCount: begin
          if (bit_cur) used_q <= used_q + CntW'(1);
          f_q <= f_nx;
        end
        StDone: begin
          done_o          <= 1'b1;
          success_o       <= ok_q;
          frame_address_o <= 32'(fa_q) << PageShift;
          used_count_o    <= used_q;
          free_count_o    <= CntW'(tot_q) - used_q;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !$past(done_o))
    else $error("result strobe held two cycles");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(used_count_o) + 32'(free_count_o) <= Frames))
    else $error("counts exceed map size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted without going busy");
endmodule
